// File: hdl/lag_pkg.sv
`timescale 1ns / 1ps
package lag_pkg;

   // payload and register widths
   localparam int KIND_W     = 2;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int ROWS_CFG_W = 6;
   localparam int COLS_CFG_W = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   // item kinds; code 3 is unused and only answers
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_STEP  = 2'd2
   } kind_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   // register reset values
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd30;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd100;

endpackage

// File: hdl/life_automaton_grid_core.sv
`timescale 1ns / 1ps
// An in-range cell write or read goes through S_WR_MOD or S_RD_WAIT before the registered rsp_valid;
//   an out-of-range address, the unused kind or a step on an empty grid set rsp_valid from S_IDLE.
// A generation step goes through S_ST_LOAD and then S_ST_RUN: the row unit handles one row per cycle
//   while the RAM read port fetches the row two below it.
// busy is high until the result cycle; the next item may be taken while rsp_valid shows.
// Synchronous reset clears the row valid flags (all cells dead, no sweep) and sets 30 x 100.
module life_automaton_grid_core #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [lag_pkg::KIND_W-1:0]       req_kind,
   input  logic [lag_pkg::ROW_W-1:0]        req_row,
   input  logic [lag_pkg::COL_W-1:0]        req_col,
   input  logic                             req_cell_value,
   output logic                             rsp_valid,
   output logic                             rsp_cell_state,
   output logic                             rsp_accepted,
   input  logic                             csr_write_en,
   input  logic [lag_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lag_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   import lag_pkg::*;

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int AW  = $clog2(MAX_ROWS + 2);
   localparam int CW  = $clog2(MAX_COLS);
   localparam int NCW = $clog2(MAX_COLS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WR_MOD,
      S_RD_WAIT,
      S_ST_LOAD,
      S_ST_RUN
   } state_type;

   state_type                state_ff, state_in;
   logic [ROWS_CFG_W-1:0]    rows_ff;
   logic [COLS_CFG_W-1:0]    cols_ff;
   logic [RW-1:0]            op_row_ff, op_row_in;
   logic [CW-1:0]            op_col_ff, op_col_in;
   logic                     op_val_ff, op_val_in;
   logic [AW-1:0]            s_row_ff, s_row_in;
   logic [MAX_COLS-1:0]      prev_ff, prev_in;
   logic [MAX_COLS-1:0]      cur_ff, cur_in;
   logic                     rd_live_ff, rd_live_in;
   logic [MAX_ROWS-1:0]      row_valid_ff, row_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_cell_ff, rsp_cell_in;
   logic                     rsp_acc_ff, rsp_acc_in;

   logic [AW-1:0]            nr;
   logic [NCW-1:0]           nc;
   logic                     inside_w;
   logic                     rd_en_w;
   logic [AW-1:0]            rd_addr_w;
   logic                     wr_en_w;
   logic [RW-1:0]            wr_addr_w;
   logic [MAX_COLS-1:0]      wr_data_w;
   logic [MAX_COLS-1:0]      ram_rd_data;
   logic [MAX_COLS-1:0]      rd_row_w;
   logic [MAX_COLS-1:0]      mod_row_w;
   logic [MAX_COLS-1:0]      new_row_w;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROWS: rows_ff <= csr_write_data[ROWS_CFG_W-1:0];
            CSR_COLS: cols_ff <= csr_write_data[COLS_CFG_W-1:0];
            default:  ;
         endcase
      end
   end

   // active size, saturated at the grid size
   assign nr = (32'(rows_ff) > MAX_ROWS) ? AW'(MAX_ROWS) : AW'(rows_ff);
   assign nc = (32'(cols_ff) > MAX_COLS) ? NCW'(MAX_COLS) : NCW'(cols_ff);

   assign inside_w = (32'(req_row) < 32'(nr)) && (32'(req_col) < 32'(nc));

   // rows never written read as dead
   assign rd_row_w = ram_rd_data & {MAX_COLS{rd_live_ff}};

   // single-cell update of the fetched row
   always_comb begin
      mod_row_w            = rd_row_w;
      mod_row_w[op_col_ff] = op_val_ff;
   end

   lag_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en_w),
      .wr_addr (wr_addr_w),
      .wr_data (wr_data_w),
      .rd_en   (rd_en_w),
      .rd_addr (rd_addr_w[RW-1:0]),
      .rd_data (ram_rd_data)
   );

   // next generation of the row in the middle of the window
   lag_row_unit #(
      .MAX_COLS (MAX_COLS)
   ) u_row_unit (
      .active_cols (nc),
      .prev_row    (prev_ff),
      .cur_row     (cur_ff),
      .next_row    (rd_row_w),
      .new_row     (new_row_w)
   );

   // sequencer next values
   always_comb begin
      state_in     = state_ff;
      op_row_in    = op_row_ff;
      op_col_in    = op_col_ff;
      op_val_in    = op_val_ff;
      s_row_in     = s_row_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_cell_in  = 1'b0;
      rsp_acc_in   = 1'b0;
      rd_en_w      = 1'b0;
      rd_addr_w    = '0;
      wr_en_w      = 1'b0;
      wr_addr_w    = op_row_ff;
      wr_data_w    = mod_row_w;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_row_in = RW'(req_row);
               op_col_in = CW'(req_col);
               op_val_in = req_cell_value;
               unique case (kind_type'(req_kind))
                  KIND_WRITE: begin
                     if (inside_w) begin
                        rd_en_w   = 1'b1;
                        rd_addr_w = AW'(req_row);
                        state_in  = S_WR_MOD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  KIND_READ: begin
                     if (inside_w) begin
                        rd_en_w   = 1'b1;
                        rd_addr_w = AW'(req_row);
                        state_in  = S_RD_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  KIND_STEP: begin
                     if (nr != '0 && nc != '0) begin
                        rd_en_w   = 1'b1;
                        rd_addr_w = '0;
                        state_in  = S_ST_LOAD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_WR_MOD: begin
            wr_en_w      = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_acc_in   = 1'b1;
            state_in     = S_IDLE;
         end
         S_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_acc_in   = 1'b1;
            rsp_cell_in  = rd_row_w[op_col_ff];
            state_in     = S_IDLE;
         end
         S_ST_LOAD: begin
            // row 0 arrived; top edge is dead; fetch row 1
            cur_in    = rd_row_w;
            prev_in   = '0;
            s_row_in  = '0;
            rd_en_w   = 1'b1;
            rd_addr_w = AW'(1);
            state_in  = S_ST_RUN;
         end
         S_ST_RUN: begin
            // write back the finished row, slide the window, fetch two rows ahead
            wr_en_w   = 1'b1;
            wr_addr_w = s_row_ff[RW-1:0];
            wr_data_w = new_row_w;
            prev_in   = cur_ff;
            cur_in    = rd_row_w;
            rd_en_w   = 1'b1;
            rd_addr_w = s_row_ff + AW'(2);
            s_row_in  = s_row_ff + AW'(1);
            if (s_row_ff + AW'(1) == nr) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // row valid flags and the liveness of the fetched row
   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en_w) begin
         row_valid_in[wr_addr_w] = 1'b1;
      end
      rd_live_in = rd_live_ff;
      if (rd_en_w) begin
         rd_live_in = (rd_addr_w < nr) && row_valid_ff[rd_addr_w[RW-1:0]];
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_row_ff   <= op_row_in;
      op_col_ff   <= op_col_in;
      op_val_ff   <= op_val_in;
      s_row_ff    <= s_row_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_state = rsp_cell_ff;
   assign rsp_accepted   = rsp_acc_ff;

endmodule

// File: hdl/lag_ram.sv
`timescale 1ns / 1ps
module lag_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lag_row_unit.sv
`timescale 1ns / 1ps
module lag_row_unit #(
   parameter int MAX_COLS = 128
) (
   input  logic [$clog2(MAX_COLS+1)-1:0] active_cols,
   input  logic [MAX_COLS-1:0]           prev_row,
   input  logic [MAX_COLS-1:0]           cur_row,
   input  logic [MAX_COLS-1:0]           next_row,
   output logic [MAX_COLS-1:0]           new_row
);

   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   function automatic logic life_rule(input logic alive, input logic [3:0] count);
      life_rule = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
   endfunction

   logic [MAX_COLS-1:0] col_mask;
   logic [MAX_COLS+1:0] prev_pad;
   logic [MAX_COLS+1:0] cur_pad;
   logic [MAX_COLS+1:0] next_pad;

   // columns beyond the active width count as dead; pad bits are the outer edges
   assign prev_pad = {1'b0, prev_row & col_mask, 1'b0};
   assign cur_pad  = {1'b0, cur_row  & col_mask, 1'b0};
   assign next_pad = {1'b0, next_row & col_mask, 1'b0};

   // one lane per column: neighbor count, then the rule
   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      logic [3:0] count_w;

      assign col_mask[c] = (NCW'(c) < active_cols);

      assign count_w = 4'(prev_pad[c]) + 4'(prev_pad[c+1]) + 4'(prev_pad[c+2])
                     + 4'(cur_pad[c])                      + 4'(cur_pad[c+2])
                     + 4'(next_pad[c]) + 4'(next_pad[c+1]) + 4'(next_pad[c+2]);

      // inactive columns keep their old value
      assign new_row[c] = col_mask[c] ? life_rule(cur_row[c], count_w) : cur_row[c];
   end

endmodule

// File: hdl/lag_checker.sv
`timescale 1ns / 1ps
module lag_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [lag_pkg::KIND_W-1:0]  req_kind,
   input logic                        rsp_valid,
   input logic                        rsp_cell_state,
   input logic                        rsp_accepted
);

   import lag_pkg::*;

   // an accepted item either occupies the block or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("transfer neither started work nor answered");

   // cell reads and writes answer without stalling, in range or out of range
   a_cell_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_READ || req_kind == KIND_WRITE))
      |-> ##2 (rsp_valid || $past(rsp_valid)))
      else $error("cell access result late");

   // the block is free again in the result cycle
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while still busy");

   // a live cell state only comes with an accepted read
   a_state_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cell_state) |-> rsp_accepted)
      else $error("cell state set on a rejected item");

   // no result without an item in flight
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start && !busy)))
      else $error("result without a transfer");

endmodule

bind life_automaton_grid_core lag_checker u_lag_checker (.*);

// File: dv/tb_life_automaton_grid_core.sv
`timescale 1ns / 1ps

// One expected answer per item
typedef struct packed {
   bit cell_state;
   bit accepted;
} cell_answer_type;

// Shadow grid, size registers and the queue of answers still owed by the block
class life_grid_scoreboard;
   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 128;

   bit [GRID_COLS-1:0]           cells [GRID_ROWS];
   bit [lag_pkg::ROWS_CFG_W-1:0] rows_cfg;
   bit [lag_pkg::COLS_CFG_W-1:0] cols_cfg;
   cell_answer_type              answers_due [$];
   int                           fail_count;

   function new();
      rows_cfg   = lag_pkg::ROWS_RESET;
      cols_cfg   = lag_pkg::COLS_RESET;
      fail_count = 0;
   endfunction

   function void set_register(logic [lag_pkg::CSR_IDX_W-1:0] index,
                              logic [lag_pkg::CSR_DATA_W-1:0] data);
      if (index == lag_pkg::CSR_ROWS) begin
         rows_cfg = data[lag_pkg::ROWS_CFG_W-1:0];
      end else begin
         cols_cfg = data[lag_pkg::COLS_CFG_W-1:0];
      end
   endfunction

   // sizes above the array saturate
   function int active_rows();
      return (int'(rows_cfg) > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
   endfunction

   function int active_cols();
      return (int'(cols_cfg) > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
   endfunction

   // one generation over the active area; cells past its edges count as dead
   function void next_generation(int nr, int nc);
      bit [GRID_COLS-1:0] old_cells [GRID_ROWS];
      int live;
      old_cells = cells;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr &&
                      c + dc >= 0 && c + dc < nc) begin
                     live += old_cells[r + dr][c + dc];
                  end
               end
            end
            cells[r][c] = old_cells[r][c] ? (live == 2 || live == 3) : (live == 3);
         end
      end
   endfunction

   // called for every accepted item transfer
   function void note_item(logic [lag_pkg::KIND_W-1:0] kind, logic [lag_pkg::ROW_W-1:0] row,
                           logic [lag_pkg::COL_W-1:0] col, logic value);
      cell_answer_type answer;
      int nr;
      int nc;
      bit in_area;
      nr      = active_rows();
      nc      = active_cols();
      in_area = (int'(row) < nr) && (int'(col) < nc);
      answer  = '0;
      case (kind)
         lag_pkg::KIND_WRITE: begin
            if (in_area) begin
               cells[row][col] = value;
               answer.accepted = 1'b1;
            end
         end
         lag_pkg::KIND_READ: begin
            if (in_area) begin
               answer.cell_state = cells[row][col];
               answer.accepted   = 1'b1;
            end
         end
         lag_pkg::KIND_STEP: begin
            if (nr > 0 && nc > 0) begin
               next_generation(nr, nc);
               answer.accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase
      answers_due.push_back(answer);
   endfunction

   function void note_failure(string msg);
      if (fail_count < 10) begin
         $display("%0t: mismatch: %s", $time, msg);
      end
      fail_count++;
   endfunction

   // called for every result transfer
   function void check_result(logic cell_state, logic accepted);
      cell_answer_type due;
      if (answers_due.size() == 0) begin
         note_failure($sformatf("unexpected result cell_state %b accepted %b",
                                cell_state, accepted));
         return;
      end
      due = answers_due.pop_front();
      if (cell_state !== due.cell_state || accepted !== due.accepted) begin
         note_failure($sformatf("cell_state exp %b got %b, accepted exp %b got %b",
                                due.cell_state, cell_state, due.accepted, accepted));
      end
   endfunction

   function void check_drained();
      if (answers_due.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", answers_due.size()));
      end
   endfunction
endclass

module tb_life_automaton_grid_core;
   import lag_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind       = '0;
   logic [ROW_W-1:0]      req_row        = '0;
   logic [COL_W-1:0]      req_col        = '0;
   logic                  req_cell_value = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_cell_state;
   logic                  rsp_accepted;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   life_grid_scoreboard board;
   int                  sender_idle_pct = 0;

   always #6 clock = ~clock;

   life_automaton_grid_core #(
      .MAX_ROWS(32),
      .MAX_COLS(128)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_cell_value(req_cell_value),
      .rsp_valid     (rsp_valid),
      .rsp_cell_state(rsp_cell_state),
      .rsp_accepted  (rsp_accepted),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_result(rsp_cell_state, rsp_accepted);
      end
   end

   // drive one item and hold it until the transfer; returns on a falling edge
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic value);
      start          <= 1'b1;
      req_kind       <= kind;
      req_row        <= row;
      req_col        <= col;
      req_cell_value <= value;
      do @(posedge clock); while (busy);
      board.note_item(kind, row, col, value);
      @(negedge clock);
   endtask

   // random sender gap, sometimes long enough to span a whole generation step
   task automatic pace_sender();
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap   = ($urandom_range(3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop sending until every owed result is back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (board.answers_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // write both size registers; the block is idle here
   task automatic write_size(input logic [CSR_DATA_W-1:0] rows,
                             input logic [CSR_DATA_W-1:0] cols);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_ROWS;
      csr_write_data <= rows;
      board.set_register(CSR_ROWS, rows);
      @(negedge clock);
      csr_index      <= CSR_COLS;
      csr_write_data <= cols;
      board.set_register(CSR_COLS, cols);
      @(negedge clock);
      csr_write_en   <= 1'b0;
      @(negedge clock);
   endtask

   // mostly small grids, now and then the extremes
   task automatic random_size();
      logic [CSR_DATA_W-1:0] rows;
      logic [CSR_DATA_W-1:0] cols;
      case ($urandom_range(9))
         6: rows = CSR_DATA_W'($urandom_range(63));
         7: rows = 8'd32;
         8: rows = 8'd63;
         9: rows = 8'd1;
         default: rows = CSR_DATA_W'($urandom_range(3, 8));
      endcase
      // upper bits fall outside the 6-bit row register
      rows[7:6] = 2'($urandom_range(3));
      case ($urandom_range(9))
         6: cols = CSR_DATA_W'($urandom_range(255));
         7: cols = 8'd128;
         8: cols = 8'd255;
         9: cols = 8'd1;
         default: cols = CSR_DATA_W'($urandom_range(3, 16));
      endcase
      wait_for_drain();
      write_size(rows, cols);
   endtask

   // mostly in-area writes and reads to grow live patterns, steps in between
   task automatic random_item();
      int                pick;
      int                nr;
      int                nc;
      logic [KIND_W-1:0] kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      pick = $urandom_range(99);
      nr   = board.active_rows();
      nc   = board.active_cols();
      if (pick < 45) begin
         kind = KIND_WRITE;
      end else if (pick < 75) begin
         kind = KIND_READ;
      end else if (pick < 93) begin
         kind = KIND_STEP;
      end else begin
         kind = KIND_UNUSED;
      end
      row = ROW_W'($urandom);
      col = COL_W'($urandom);
      if (nr > 0 && nc > 0 && $urandom_range(99) < 80) begin
         row = ROW_W'($urandom_range(nr - 1));
         col = COL_W'($urandom_range(nc - 1));
      end
      send_item(kind, row, col, $urandom_range(99) < 55);
      pace_sender();
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size 30 x 100: cleared grid, out-of-area addresses, unused kind
      send_item(KIND_READ, 5'd0, 7'd0, 1'b0);
      send_item(KIND_READ, 5'd31, 7'd127, 1'b0);
      send_item(KIND_UNUSED, '1, '1, 1'b1);
      // corner L-shape grows into a block, lone far corner cell dies
      send_item(KIND_WRITE, 5'd0, 7'd0, 1'b1);
      send_item(KIND_WRITE, 5'd0, 7'd1, 1'b1);
      send_item(KIND_WRITE, 5'd1, 7'd0, 1'b1);
      send_item(KIND_WRITE, 5'd29, 7'd99, 1'b1);
      send_item(KIND_WRITE, 5'd29, 7'd100, 1'b1);
      send_item(KIND_WRITE, 5'd30, 7'd0, 1'b1);
      send_item(KIND_STEP, 5'd0, 7'd0, 1'b0);
      send_item(KIND_READ, 5'd1, 7'd1, 1'b0);
      send_item(KIND_READ, 5'd29, 7'd99, 1'b0);
      send_item(KIND_WRITE, 5'd0, 7'd0, 1'b0);

      // empty area: zero rows, then zero columns
      wait_for_drain();
      write_size(8'd0, 8'd100);
      send_item(KIND_STEP, 5'd0, 7'd0, 1'b0);
      send_item(KIND_READ, 5'd0, 7'd1, 1'b0);
      wait_for_drain();
      write_size(8'd3, 8'd0);
      send_item(KIND_STEP, 5'd0, 7'd0, 1'b0);

      // oversize registers saturate at the full array; far corner is usable
      wait_for_drain();
      write_size(8'd63, 8'd255);
      send_item(KIND_WRITE, 5'd31, 7'd127, 1'b1);
      send_item(KIND_WRITE, 5'd31, 7'd126, 1'b1);
      send_item(KIND_WRITE, 5'd30, 7'd127, 1'b1);
      send_item(KIND_STEP, 5'd0, 7'd0, 1'b0);
      send_item(KIND_READ, 5'd30, 7'd126, 1'b0);

      // 3 x 3 blinker; the far corner block sits outside and must stay put
      wait_for_drain();
      write_size(8'd3, 8'd3);
      send_item(KIND_WRITE, 5'd1, 7'd0, 1'b1);
      send_item(KIND_WRITE, 5'd1, 7'd1, 1'b1);
      send_item(KIND_WRITE, 5'd1, 7'd2, 1'b1);
      send_item(KIND_STEP, 5'd0, 7'd0, 1'b0);
      send_item(KIND_READ, 5'd0, 7'd1, 1'b0);
      wait_for_drain();
      write_size(8'd32, 8'd128);
      send_item(KIND_READ, 5'd31, 7'd127, 1'b0);

      // random part: busy sender, mostly idle sender, then back to back
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 84 : 0;
         repeat (3) begin
            random_size();
            repeat (50) random_item();
         end
      end

      wait_for_drain();
      repeat (40) @(negedge clock);
      board.check_drained();
      if (board.fail_count == 0) begin
         $display("PASS life_automaton_grid_core");
      end else begin
         $display("FAIL life_automaton_grid_core");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAIL life_automaton_grid_core");
      $finish;
   end

endmodule

// File: sim.f
hdl/lag_pkg.sv
hdl/lag_ram.sv
hdl/lag_row_unit.sv
hdl/life_automaton_grid_core.sv
hdl/lag_checker.sv
dv/tb_life_automaton_grid_core.sv
